>>> rtl/core/rbpg_pkg.sv
// rbpg_pkg: shared types, constants and helpers for the ROM bank and paged RAM gate.
// Used by every module under rtl/core; depends on nothing.
package rbpg_pkg;

  localparam int RAM_DEPTH   = 2048;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int CURSOR_W    = 6;
  localparam int PAGE_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int RAW_W       = 17;

  localparam logic [7:0] WIN_LO_PAGE = 8'hCC;
  localparam logic [7:0] WIN_HI_PAGE = 8'hCE;
  localparam logic [7:0] OFF_IWM     = 8'h40;
  localparam logic [7:0] OFF_CUR_CLR = 8'hA0;

  localparam int REG_IDX_IS_PLUS = 0;
  localparam int REG_IDX_HAS_ALT = 1;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_SRESET = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    RGN_NONE,
    RGN_OTHER,
    RGN_IWM,
    RGN_DRV_ON,
    RGN_DRV_OFF,
    RGN_RAM,
    RGN_RAM_ADV,
    RGN_HEAD0,
    RGN_HEAD1,
    RGN_CUR_CLR
  } region_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              below_io;
    region_t           region;
    logic [PAGE_W-1:0] low;
    logic [13:0]       alt_off;
    logic [7:0]        wdata;
    logic [7:0]        float_bus;
  } op_t;

  typedef struct packed {
    logic is_plus;
    logic has_alt_bank;
  } cfg_t;

  typedef struct packed {
    logic        handled;
    logic        alt_rom_read;
    logic [13:0] alt_rom_offset;
    logic        iwm_reset;
    logic        bank_now;
    logic        internal_drive;
    logic        select_35;
    logic        head_one;
  } flags_t;

  function automatic logic [RAM_AW-1:0] ram_index(input logic [CURSOR_W-1:0] cursor,
                                                  input logic [PAGE_W-1:0] low);
    logic [RAW_W-1:0] r;
    r = {{(RAW_W - CURSOR_W - PAGE_W){1'b0}}, cursor, low};
    for (int i = 0; i < 8; i++) begin
      if (r >= RAW_W'(RAM_DEPTH)) r = r - RAW_W'(RAM_DEPTH);
    end
    return r[RAM_AW-1:0];
  endfunction

endpackage

>>> rtl/core/rbpg_cfg.sv
// rbpg_cfg: APB-style configuration registers (is_plus, has_alt_bank).
// Depends on rbpg_pkg.
module rbpg_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rbpg_pkg::cfg_t    cfg
);

  logic is_plus_r, is_plus_nxt;
  logic has_alt_r, has_alt_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    is_plus_nxt = is_plus_r;
    has_alt_nxt = has_alt_r;
    if (wr_en) begin
      if (paddr[2] == 1'(rbpg_pkg::REG_IDX_IS_PLUS)) is_plus_nxt = pwdata[0];
      else has_alt_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_plus_r <= 1'b0;
      has_alt_r <= 1'b1;
    end else begin
      is_plus_r <= is_plus_nxt;
      has_alt_r <= has_alt_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == 1'(rbpg_pkg::REG_IDX_HAS_ALT)) prdata[0] = has_alt_r;
    else prdata[0] = is_plus_r;
  end

  assign cfg.is_plus      = is_plus_r;
  assign cfg.has_alt_bank = has_alt_r;

endmodule

>>> rtl/core/rbpg_front.sv
// rbpg_front: accepts commands and classifies the address into a window region.
// Depends on rbpg_pkg; feeds rbpg_queue.
module rbpg_front (
  input  logic            start,
  input  logic            full,
  input  logic [1:0]      in_cmd,
  input  logic [15:0]     in_addr,
  input  logic [7:0]      in_wdata,
  input  logic [7:0]      in_float_bus,
  output logic            push,
  output rbpg_pkg::op_t   op
);

  logic [7:0] lo;
  logic       win_lo;
  logic       win_hi;

  assign push   = start && !full;
  assign lo     = in_addr[7:0];
  assign win_lo = in_addr[15:8] == rbpg_pkg::WIN_LO_PAGE;
  assign win_hi = in_addr[15:8] == rbpg_pkg::WIN_HI_PAGE;

  always_comb begin
    op.cmd       = rbpg_pkg::cmd_t'(in_cmd);
    op.below_io  = in_addr[15:14] != 2'b11;
    op.low       = lo[4:0];
    op.alt_off   = in_addr[13:0];
    op.wdata     = in_wdata;
    op.float_bus = in_float_bus;
    op.region    = rbpg_pkg::RGN_NONE;
    if (win_lo) begin
      op.region = rbpg_pkg::RGN_OTHER;
      if (lo == rbpg_pkg::OFF_IWM) op.region = rbpg_pkg::RGN_IWM;
      else if (lo[7:5] == 3'b100) op.region = rbpg_pkg::RGN_DRV_ON;
      else if (lo[7:5] == 3'b110) op.region = rbpg_pkg::RGN_DRV_OFF;
    end else if (win_hi) begin
      op.region = rbpg_pkg::RGN_OTHER;
      unique case (lo[7:5])
        3'b000:  op.region = rbpg_pkg::RGN_RAM;
        3'b001:  op.region = rbpg_pkg::RGN_RAM_ADV;
        3'b010:  op.region = rbpg_pkg::RGN_HEAD0;
        3'b011:  op.region = rbpg_pkg::RGN_HEAD1;
        default: begin
          if (lo == rbpg_pkg::OFF_CUR_CLR) op.region = rbpg_pkg::RGN_CUR_CLR;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/rbpg_queue.sv
// rbpg_queue: short register queue of classified commands between front and back.
// Depends on rbpg_pkg.
module rbpg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rbpg_pkg::op_t   push_op,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output rbpg_pkg::op_t   head_op
);

  rbpg_pkg::op_t entry_r [rbpg_pkg::QUEUE_DEPTH];
  logic [rbpg_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rbpg_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rbpg_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full      = count_r == rbpg_pkg::QCNT_W'(rbpg_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_op   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == rbpg_pkg::QPTR_W'(rbpg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == rbpg_pkg::QPTR_W'(rbpg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_op;
  end

endmodule

>>> rtl/core/rbpg_back.sv
// rbpg_back: carries out queued commands on the window RAM, cursor and drive flags,
// and registers one result per command. Depends on rbpg_pkg.
module rbpg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rbpg_pkg::cfg_t  cfg,
  input  logic            op_valid,
  input  rbpg_pkg::op_t   op,
  output logic            pop,
  output logic            out_valid,
  output logic [7:0]      out_rdata,
  output rbpg_pkg::flags_t out_flags
);

  logic [7:0] mem [rbpg_pkg::RAM_DEPTH];

  logic [rbpg_pkg::CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic bank_r, bank_nxt;
  logic drv_int_r, drv_int_nxt;
  logic drv_35_r, drv_35_nxt;
  logic head_r, head_nxt;

  logic [rbpg_pkg::RAM_AW-1:0] idx;
  logic win_hit, ram_rd, ram_wr;
  logic [7:0] fb_val;
  rbpg_pkg::flags_t flags;

  logic valid_r;
  logic use_ram_r;
  logic [7:0] fb_r;
  logic [7:0] rd_data_r;
  rbpg_pkg::flags_t flags_r;

  assign pop     = op_valid;
  assign idx     = rbpg_pkg::ram_index(cursor_r, op.low);
  assign win_hit = cfg.is_plus && bank_r && (op.region != rbpg_pkg::RGN_NONE) && !op.below_io;

  always_comb begin
    cursor_nxt  = cursor_r;
    bank_nxt    = bank_r;
    drv_int_nxt = drv_int_r;
    drv_35_nxt  = drv_35_r;
    head_nxt    = head_r;
    ram_rd      = 1'b0;
    ram_wr      = 1'b0;
    fb_val      = 8'd0;
    flags       = '0;
    if (op_valid) begin
      unique case (op.cmd)
        rbpg_pkg::CMD_TOGGLE: begin
          bank_nxt      = !bank_r;
          flags.handled = 1'b1;
          if (cfg.is_plus && bank_r) begin
            cursor_nxt  = '0;
            drv_int_nxt = 1'b0;
            drv_35_nxt  = 1'b0;
          end
        end
        rbpg_pkg::CMD_SRESET: begin
          bank_nxt = 1'b0;
        end
        rbpg_pkg::CMD_READ: begin
          if (win_hit) begin
            flags.handled = 1'b1;
            fb_val        = op.float_bus;
            case (op.region)
              rbpg_pkg::RGN_RAM: ram_rd = 1'b1;
              rbpg_pkg::RGN_RAM_ADV: begin
                ram_rd     = 1'b1;
                cursor_nxt = cursor_r + 1'b1;
              end
              rbpg_pkg::RGN_HEAD0:   head_nxt   = 1'b0;
              rbpg_pkg::RGN_HEAD1:   head_nxt   = 1'b1;
              rbpg_pkg::RGN_CUR_CLR: cursor_nxt = '0;
              default: ;
            endcase
          end else if (!op.below_io && cfg.has_alt_bank && bank_r) begin
            flags.handled        = 1'b1;
            flags.alt_rom_read   = 1'b1;
            flags.alt_rom_offset = op.alt_off;
          end
        end
        rbpg_pkg::CMD_WRITE: begin
          if (win_hit) begin
            flags.handled = 1'b1;
            case (op.region)
              rbpg_pkg::RGN_IWM:     flags.iwm_reset = 1'b1;
              rbpg_pkg::RGN_DRV_ON:  drv_int_nxt     = 1'b1;
              rbpg_pkg::RGN_DRV_OFF: drv_int_nxt     = 1'b0;
              rbpg_pkg::RGN_RAM:     ram_wr          = 1'b1;
              rbpg_pkg::RGN_RAM_ADV: begin
                ram_wr     = 1'b1;
                cursor_nxt = cursor_r + 1'b1;
              end
              rbpg_pkg::RGN_HEAD0:   drv_35_nxt = 1'b0;
              rbpg_pkg::RGN_HEAD1:   drv_35_nxt = 1'b1;
              rbpg_pkg::RGN_CUR_CLR: cursor_nxt = '0;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    flags.bank_now       = bank_nxt;
    flags.internal_drive = drv_int_nxt;
    flags.select_35      = drv_35_nxt;
    flags.head_one       = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= '0;
      bank_r    <= 1'b0;
      drv_int_r <= 1'b0;
      drv_35_r  <= 1'b0;
      head_r    <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      cursor_r  <= cursor_nxt;
      bank_r    <= bank_nxt;
      drv_int_r <= drv_int_nxt;
      drv_35_r  <= drv_35_nxt;
      head_r    <= head_nxt;
      valid_r   <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_wr) mem[idx] <= op.wdata;
    if (ram_rd) rd_data_r <= mem[idx];
  end

  always_ff @(posedge clk) begin
    use_ram_r <= ram_rd;
    fb_r      <= fb_val;
    flags_r   <= flags;
  end

  assign out_valid = valid_r;
  assign out_rdata = use_ram_r ? rd_data_r : fb_r;
  assign out_flags = flags_r;

endmodule

>>> rtl/core/rom_bank_and_paged_ram_gate.sv
// rom_bank_and_paged_ram_gate: top level of the ROM bank and paged RAM gate.
// Instantiates rbpg_cfg, rbpg_front, rbpg_queue and rbpg_back; depends on rbpg_pkg.
//
// Usage:
//   Input channel: drive in_cmd, in_addr, in_wdata, in_float_bus and raise start;
//   the transfer takes place at a rising edge with start high and busy low.
//   Result channel: out_valid is high for exactly one cycle per command, with all
//   out_ fields valid in that cycle; the receiver cannot hold results off.
//   An accepted command passes a queue entry; the back end registers its result.
//   Throughput: one command per cycle; the back end updates the page cursor and
//   issues the window RAM access in the same cycle.
//   busy follows a full two-entry command queue; the back end drains one command
//   per cycle, so the queue never fills and busy stays low.
//   Configuration: APB-style write port, is_plus at byte address 0 and
//   has_alt_bank at byte address 4; pready is always high.
//   Reset (rst_n low, synchronous): cursor, bank and drive flags clear,
//   is_plus goes to 0, has_alt_bank to 1, queue empties. Window RAM contents
//   are not cleared and read as undefined until written.
module rom_bank_and_paged_ram_gate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [7:0]  in_float_bus,
  output logic        out_valid,
  output logic        out_handled,
  output logic [7:0]  out_rdata,
  output logic        out_alt_rom_read,
  output logic [13:0] out_alt_rom_offset,
  output logic        out_iwm_reset,
  output logic        out_bank_now,
  output logic        out_internal_drive,
  output logic        out_select_35,
  output logic        out_head_one,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rbpg_pkg::cfg_t   cfg;
  rbpg_pkg::op_t    push_op;
  rbpg_pkg::op_t    head_op;
  rbpg_pkg::flags_t flags;
  logic push, full, not_empty, pop;

  rbpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbpg_front u_front (
    .start        (start),
    .full         (full),
    .in_cmd       (in_cmd),
    .in_addr      (in_addr),
    .in_wdata     (in_wdata),
    .in_float_bus (in_float_bus),
    .push         (push),
    .op           (push_op)
  );

  rbpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_op   (head_op)
  );

  rbpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .op_valid  (not_empty),
    .op        (head_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_rdata (out_rdata),
    .out_flags (flags)
  );

  assign busy               = full;
  assign out_handled        = flags.handled;
  assign out_alt_rom_read   = flags.alt_rom_read;
  assign out_alt_rom_offset = flags.alt_rom_offset;
  assign out_iwm_reset      = flags.iwm_reset;
  assign out_bank_now       = flags.bank_now;
  assign out_internal_drive = flags.internal_drive;
  assign out_select_35      = flags.select_35;
  assign out_head_one       = flags.head_one;

endmodule

>>> test/rbpg_checker.sv
// rbpg_checker: watches the command, result and register ports of the ROM bank
// and paged RAM gate, predicts each result and compares it field by field.
// Depends on rbpg_pkg for the command codes, RAM depth and register indexes.
module rbpg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [7:0]  in_float_bus,
  input  logic        out_valid,
  input  logic        out_handled,
  input  logic [7:0]  out_rdata,
  input  logic        out_alt_rom_read,
  input  logic [13:0] out_alt_rom_offset,
  input  logic        out_iwm_reset,
  input  logic        out_bank_now,
  input  logic        out_internal_drive,
  input  logic        out_select_35,
  input  logic        out_head_one,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] WIN_BASE  = 16'hCC00;
  localparam logic [15:0] IO_BASE   = 16'hC000;
  localparam logic [15:0] OFF_IWMR  = 16'h040;
  localparam logic [15:0] OFF_DRVON = 16'h080;
  localparam logic [15:0] OFF_DRVOF = 16'h0C0;
  localparam logic [15:0] OFF_RAM   = 16'h200;
  localparam logic [15:0] OFF_RADV  = 16'h220;
  localparam logic [15:0] OFF_HD0   = 16'h240;
  localparam logic [15:0] OFF_HD1   = 16'h260;
  localparam logic [15:0] OFF_CLR   = 16'h2A0;

  typedef struct packed {
    logic        handled;
    logic [7:0]  rdata;
    logic        alt_read;
    logic [13:0] alt_off;
    logic        iwm;
    logic        bank;
    logic        drv_int;
    logic        drv_35;
    logic        head;
  } gate_resp_t;

  logic [7:0]                    ram_mirror [rbpg_pkg::RAM_DEPTH];
  logic [rbpg_pkg::CURSOR_W-1:0] cursor;
  logic                          bank, drv_int, drv_35, head, plus, alt_bank;
  gate_resp_t                    pending_resp [$];
  gate_resp_t                    want;
  gate_resp_t                    got;

  function automatic gate_resp_t gate_access(rbpg_pkg::cmd_t c, logic [15:0] a,
                                             logic [7:0] wd, logic [7:0] fb);
    gate_resp_t r;
    logic [15:0] off;
    logic        win_on, in_win;
    int          idx;
    r      = '0;
    off    = a - WIN_BASE;
    win_on = plus && bank;
    in_win = (a[15:8] == rbpg_pkg::WIN_LO_PAGE) || (a[15:8] == rbpg_pkg::WIN_HI_PAGE);
    idx    = (int'(cursor) * 32 + int'(off[4:0])) % rbpg_pkg::RAM_DEPTH;
    case (c)
      rbpg_pkg::CMD_TOGGLE: begin
        bank = ~bank;
        if (plus && !bank) begin
          cursor  = '0;
          drv_int = 1'b0;
          drv_35  = 1'b0;
        end
        r.handled = 1'b1;
      end
      rbpg_pkg::CMD_SRESET: bank = 1'b0;
      rbpg_pkg::CMD_READ: begin
        if (a >= IO_BASE) begin
          if (win_on && in_win) begin
            r.handled = 1'b1;
            if (off >= OFF_RAM && off < OFF_RADV) begin
              r.rdata = ram_mirror[idx];
            end else if (off >= OFF_RADV && off < OFF_HD0) begin
              r.rdata = ram_mirror[idx];
              cursor  = cursor + 1'b1;
            end else begin
              r.rdata = fb;
              if (off >= OFF_HD0 && off < OFF_HD1) head = 1'b0;
              if (off >= OFF_HD1 && off < OFF_HD1 + 16'h20) head = 1'b1;
              if (off == OFF_CLR) cursor = '0;
            end
          end else if (alt_bank && bank) begin
            r.handled  = 1'b1;
            r.alt_read = 1'b1;
            r.alt_off  = 14'(a - IO_BASE);
          end
        end
      end
      default: begin
        if (a >= IO_BASE && win_on && in_win) begin
          r.handled = 1'b1;
          if (off == OFF_IWMR) r.iwm = 1'b1;
          else if (off >= OFF_DRVON && off < OFF_DRVON + 16'h20) drv_int = 1'b1;
          else if (off >= OFF_DRVOF && off < OFF_DRVOF + 16'h20) drv_int = 1'b0;
          else if (off >= OFF_RAM && off < OFF_RADV) ram_mirror[idx] = wd;
          else if (off >= OFF_RADV && off < OFF_HD0) begin
            ram_mirror[idx] = wd;
            cursor          = cursor + 1'b1;
          end
          else if (off >= OFF_HD0 && off < OFF_HD1) drv_35 = 1'b0;
          else if (off >= OFF_HD1 && off < OFF_HD1 + 16'h20) drv_35 = 1'b1;
          else if (off == OFF_CLR) cursor = '0;
        end
      end
    endcase
    r.bank    = bank;
    r.drv_int = drv_int;
    r.drv_35  = drv_35;
    r.head    = head;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cursor   = '0;
      bank     = 1'b0;
      drv_int  = 1'b0;
      drv_35   = 1'b0;
      head     = 1'b0;
      plus     = 1'b0;
      alt_bank = 1'b1;
      pending_resp.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (pending_resp.size() == 0) begin
          $display("%0t: result with no outstanding access, handled %0h", $time, out_handled);
          mismatches++;
        end else begin
          want = pending_resp.pop_front();
          check_field("handled", want.handled, out_handled);
          check_field("rdata", want.rdata, out_rdata);
          check_field("alt_rom_read", want.alt_read, out_alt_rom_read);
          check_field("alt_rom_offset", want.alt_off, out_alt_rom_offset);
          check_field("iwm_reset", want.iwm, out_iwm_reset);
          check_field("bank_now", want.bank, out_bank_now);
          check_field("internal_drive", want.drv_int, out_internal_drive);
          check_field("select_35", want.drv_35, out_select_35);
          check_field("head_one", want.head, out_head_one);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(4 * rbpg_pkg::REG_IDX_IS_PLUS)) plus = pwdata[0];
        if (paddr == 3'(4 * rbpg_pkg::REG_IDX_HAS_ALT)) alt_bank = pwdata[0];
      end
      if (start && !busy) begin
        got = gate_access(rbpg_pkg::cmd_t'(in_cmd), in_addr, in_wdata, in_float_bus);
        pending_resp.insert(pending_resp.size(), got);
      end
      pending <= pending_resp.size();
    end
  end

endmodule

>>> test/rom_bank_and_paged_ram_gate_tb.sv
// rom_bank_and_paged_ram_gate_tb: stimulus and verdict for the ROM bank and paged RAM gate.
// Writes the first window RAM pages, runs directed and random accesses under several
// register settings; depends on rbpg_pkg, the block and rbpg_checker.
module rom_bank_and_paged_ram_gate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = rbpg_pkg::CMD_READ;
  logic [15:0] in_addr = '0;
  logic [7:0]  in_wdata = '0;
  logic [7:0]  in_float_bus = '0;
  logic        out_valid, out_handled, out_alt_rom_read, out_iwm_reset;
  logic [7:0]  out_rdata;
  logic [13:0] out_alt_rom_offset;
  logic        out_bank_now, out_internal_drive, out_select_35, out_head_one;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches, pending;
  int          stall_cnt = 0;
  bit          gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rom_bank_and_paged_ram_gate u_top (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_addr, .in_wdata, .in_float_bus,
    .out_valid, .out_handled, .out_rdata, .out_alt_rom_read, .out_alt_rom_offset,
    .out_iwm_reset, .out_bank_now, .out_internal_drive, .out_select_35, .out_head_one,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rbpg_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_addr, .in_wdata, .in_float_bus,
    .out_valid, .out_handled, .out_rdata, .out_alt_rom_read, .out_alt_rom_offset,
    .out_iwm_reset, .out_bank_now, .out_internal_drive, .out_select_35, .out_head_one,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .pending
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("rom_bank_and_paged_ram_gate test failed");
      $finish;
    end
  end

  task automatic issue(input rbpg_pkg::cmd_t c, input logic [15:0] a, input logic [7:0] wd,
                       input logic [7:0] fb);
    if (gaps_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 37) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= c;
    in_addr      <= a;
    in_wdata     <= wd;
    in_float_bus <= fb;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic plus, input logic alt);
    for (int i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * i);
      pwdata  <= {31'd0, (i == rbpg_pkg::REG_IDX_IS_PLUS) ? plus : alt};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_addr();
    logic [7:0] pg;
    pg = $urandom_range(1) ? rbpg_pkg::WIN_HI_PAGE : rbpg_pkg::WIN_LO_PAGE;
    case ($urandom_range(11))
      0, 1, 2, 3: return {rbpg_pkg::WIN_HI_PAGE, 8'($urandom_range(8'h3F))};
      4:          return {rbpg_pkg::WIN_HI_PAGE, 8'($urandom_range(8'h7F, 8'h40))};
      5:          return {rbpg_pkg::WIN_HI_PAGE, 8'hA0};
      6:          return {rbpg_pkg::WIN_LO_PAGE, rbpg_pkg::OFF_IWM};
      7:          return {rbpg_pkg::WIN_LO_PAGE, 8'($urandom_range(8'hDF, 8'h80))};
      8:          return {pg, 8'($urandom)};
      9:          return 16'($urandom_range(16'hFFFF, 16'hC000));
      10:         return 16'($urandom_range(16'hBFFF));
      default:    return {rbpg_pkg::WIN_HI_PAGE, 8'($urandom_range(8'hFF, 8'h80))};
    endcase
  endfunction

  task automatic random_phase(input int count);
    int             sel;
    rbpg_pkg::cmd_t c;
    logic [15:0]    a;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 44) c = rbpg_pkg::CMD_READ;
      else if (sel < 88) c = rbpg_pkg::CMD_WRITE;
      else if (sel < 96) c = rbpg_pkg::CMD_TOGGLE;
      else c = rbpg_pkg::CMD_SRESET;
      a = pick_addr();
      if (c == rbpg_pkg::CMD_READ && a[15:8] == rbpg_pkg::WIN_HI_PAGE && a[7:6] == 2'b00) begin
        issue(rbpg_pkg::CMD_WRITE, {rbpg_pkg::WIN_HI_PAGE, 3'b000, a[4:0]}, 8'($urandom),
              8'h00);
      end
      issue(c, a, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(1'b1, 1'b1);
    issue(rbpg_pkg::CMD_TOGGLE, 16'h0000, 8'h00, 8'h00);
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 32; k++) begin
        issue(rbpg_pkg::CMD_WRITE, (k == 31) ? 16'hCE3F : 16'hCE00 + 16'(k), 8'($urandom),
              8'h00);
      end
    end
    issue(rbpg_pkg::CMD_WRITE, 16'hCEA0, 8'h00, 8'h00);

    issue(rbpg_pkg::CMD_READ, 16'hCE00, 8'h00, 8'hFF);
    issue(rbpg_pkg::CMD_READ, 16'hCE1F, 8'hFF, 8'h00);
    issue(rbpg_pkg::CMD_READ, 16'hCE20, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_READ, 16'hCE3F, 8'h00, 8'hFF);
    issue(rbpg_pkg::CMD_READ, 16'hCE7F, 8'h00, 8'hA5);
    issue(rbpg_pkg::CMD_READ, 16'hCE40, 8'h00, 8'h5A);
    issue(rbpg_pkg::CMD_WRITE, 16'hCC40, 8'hFF, 8'h00);
    issue(rbpg_pkg::CMD_WRITE, 16'hCC9F, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_WRITE, 16'hCE60, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_READ, 16'hCEA0, 8'h00, 8'hFF);
    issue(rbpg_pkg::CMD_WRITE, 16'hCE3F, 8'hFF, 8'h00);
    issue(rbpg_pkg::CMD_WRITE, 16'hCEA0, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_WRITE, 16'hCEFF, 8'hFF, 8'hFF);
    issue(rbpg_pkg::CMD_READ, 16'hCCFF, 8'h00, 8'hFF);
    issue(rbpg_pkg::CMD_READ, 16'hCD00, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_READ, 16'hFFFF, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_READ, 16'hC000, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_READ, 16'hBFFF, 8'h00, 8'hFF);
    issue(rbpg_pkg::CMD_WRITE, 16'h0000, 8'hFF, 8'h00);
    issue(rbpg_pkg::CMD_WRITE, 16'hCC80, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_WRITE, 16'hC000, 8'hFF, 8'h00);
    issue(rbpg_pkg::CMD_TOGGLE, 16'hFFFF, 8'hFF, 8'hFF);
    issue(rbpg_pkg::CMD_READ, 16'hCE00, 8'h00, 8'hFF);
    issue(rbpg_pkg::CMD_TOGGLE, 16'h0000, 8'h00, 8'h00);
    issue(rbpg_pkg::CMD_SRESET, 16'hFFFF, 8'hFF, 8'hFF);

    random_phase(100);
    drain();
    set_mode(1'b1, 1'b0);
    gaps_on = 1'b0;
    random_phase(80);
    drain();
    gaps_on = 1'b1;
    set_mode(1'b0, 1'b1);
    random_phase(70);
    drain();
    set_mode(1'b0, 1'b0);
    random_phase(60);
    drain();
    set_mode(1'b1, 1'b1);
    random_phase(120);
    drain();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("rom_bank_and_paged_ram_gate test passed");
    end else begin
      $display("rom_bank_and_paged_ram_gate test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rbpg_pkg.sv
rtl/core/rbpg_cfg.sv
rtl/core/rbpg_front.sv
rtl/core/rbpg_queue.sv
rtl/core/rbpg_back.sv
rtl/core/rom_bank_and_paged_ram_gate.sv
test/rbpg_checker.sv
test/rom_bank_and_paged_ram_gate_tb.sv
